// ===== hw/rtl/stts_pkg.sv =====
// Shared types and constants for the sorted-table ternary search block.
// No dependencies; sorted_table_ternary_search_unit imports this package.
package stts_pkg;

  // Default table size
  localparam int TABLE_DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int LEN_W   = 11;
  localparam int ENTRY_W = 10;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  // Request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [PADDR_W-3:0] REG_TABLE_LENGTH = '0;

  typedef struct packed {
    logic                     req_type;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [DATA_W-1:0] data_value;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [ENTRY_W-1:0] found_index;
  } out_beat_t;

endpackage

// ===== hw/rtl/stts_div3.sv =====
// Two-stage divide-by-three unit: reciprocal multiply, then one correction.
// Depends on nothing; shared by every probe round of the search sequencer.
module stts_div3 #(
  parameter int W = 10
) (
  input  logic         clk_i,
  input  logic [W-1:0] x_i,
  output logic [W-1:0] q_o
);

  // floor(2^W / 3): estimate is exact or one short
  localparam logic [W-1:0] RECIP = W'((2 ** W) / 3);

  logic [2*W-1:0] prod_q;
  logic [W-1:0]   x_q;
  logic [W-1:0]   est;
  logic [W+1:0]   est3;
  logic [W+1:0]   rem;
  logic [W-1:0]   q_q;

  // Stage one: multiply by the reciprocal
  always_ff @(posedge clk_i) begin
    prod_q <= {{W{1'b0}}, x_i} * {{W{1'b0}}, RECIP};
    x_q    <= x_i;
  end

  // Stage two: bump the estimate when the remainder reaches three
  assign est  = prod_q[2*W-1:W];
  assign est3 = {2'b00, est} + {1'b0, est, 1'b0};
  assign rem  = {2'b00, x_q} - est3;

  always_ff @(posedge clk_i) begin
    if (rem >= (W+2)'(3)) begin
      q_q <= est + W'(1);
    end else begin
      q_q <= est;
    end
  end

  assign q_o = q_q;

endmodule

// ===== hw/rtl/stts_mem.sv =====
// Key table storage: one write port, one registered read port.
// Depends on nothing; written by load beats, read by the probe sequencer.
module stts_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read every cycle, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sorted_table_ternary_search_unit.sv =====
// Top level of the sorted-table ternary search block: config register,
// probe sequencer and result register. Uses stts_pkg, stts_div3, stts_mem.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes load and search
//   beats. A load writes one table entry in the accept cycle and gives no
//   result; loads at or beyond TABLE_DEPTH are dropped. A search gives one
//   output beat (out_valid_o / out_stall_i / out_data_o) with found and
//   found_index.
//   The APB port holds table_length at byte address 0; searches cover
//   entries 0 .. min(table_length, TABLE_DEPTH) - 1.
//   A search runs rounds of two divider stages, then two table reads through
//   the single read port with one shared compare, at most about
//   log3(table_length) + 1 rounds (7 for 1024 entries); a hit then goes to
//   S_DONE directly, a miss by way of S_MUL. An empty table is answered from
//   S_MUL without a table read. The next beat is accepted once the result
//   registers and the sequencer is back in S_IDLE. Loads leave the sequencer
//   in S_IDLE, so they can follow each other without a stall.
//   The block holds in_stall_o high while a search runs. A finished result
//   waits in the output register; while the receiver stalls a waiting beat,
//   the next search holds its result until the register frees up.
//   Reset clears table_length and the control state; table contents are
//   undefined until loaded.
module sorted_table_ternary_search_unit #(
  parameter int TABLE_DEPTH = stts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  stts_pkg::in_beat_t            in_data_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output stts_pkg::out_beat_t           out_data_o,
  // Config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stts_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import stts_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = IW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_FIX, S_RD1, S_CMP1, S_CMP2, S_DONE
  } state_e;

  state_e                 state_q;
  logic [LEN_W-1:0]       table_length_q;
  logic signed [CW-1:0]   lo_q, hi_q, m1_q, m2_q;
  logic signed [CW-1:0]   m1_c, m2_c, hi_init;
  logic signed [DATA_W-1:0] key_q, entry;
  logic                   eq1_q, lt1_q;
  logic                   res_found_q;
  logic [ENTRY_W-1:0]     res_idx_q;
  logic                   out_valid_q;
  out_beat_t              out_data_q;
  logic [CW-1:0]          diff;
  logic [IW-1:0]          third;
  logic [IW-1:0]          raddr;
  logic [DATA_W-1:0]      rdata;
  logic                   in_acc, mem_we, cmp_eq, cmp_lt, cmp_gt;
  logic [31:0]            len_ext, len_sat;
  logic [IW+ENTRY_W-1:0]  waddr_ext, m1_ext, m2_ext;
  logic                   cfg_wr;

  // Config register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_TABLE_LENGTH) begin
      table_length_q <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_TABLE_LENGTH) begin
      prdata = {{(32-LEN_W){1'b0}}, table_length_q};
    end
  end

  // Input handshake and table writes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign waddr_ext  = {{IW{1'b0}}, in_data_i.entry_index};
  assign mem_we     = in_acc && (in_data_i.req_type == REQ_LOAD) &&
                      ({{(32-ENTRY_W){1'b0}}, in_data_i.entry_index} < 32'(TABLE_DEPTH));

  // Clamp the used length to the table size
  assign len_ext = {{(32-LEN_W){1'b0}}, table_length_q};
  assign len_sat = (len_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : len_ext;
  assign hi_init = CW'(len_sat) - CW'(1);

  // Probe points from the shared divider
  assign diff = hi_q - lo_q;
  assign m1_c = lo_q + $signed({2'b00, third});
  assign m2_c = hi_q - $signed({2'b00, third});

  stts_div3 #(
    .W (IW)
  ) u_div3 (
    .clk_i (clk_i),
    .x_i   (diff[IW-1:0]),
    .q_o   (third)
  );

  // One read port: m1 first, then m2
  assign raddr = (state_q == S_CMP1) ? m2_q[IW-1:0] : m1_c[IW-1:0];

  stts_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW),
    .DW    (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_ext[IW-1:0]),
    .wdata_i (in_data_i.data_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared key compare
  assign entry  = $signed(rdata);
  assign cmp_eq = (key_q == entry);
  assign cmp_lt = (key_q < entry);
  assign cmp_gt = (key_q > entry);

  assign m1_ext = {{ENTRY_W{1'b0}}, m1_q[IW-1:0]};
  assign m2_ext = {{ENTRY_W{1'b0}}, m2_q[IW-1:0]};

  // Probe sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lo_q        <= '0;
      hi_q        <= '0;
      m1_q        <= '0;
      m2_q        <= '0;
      key_q       <= '0;
      eq1_q       <= 1'b0;
      lt1_q       <= 1'b0;
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Drop the output beat once taken, unless a new one loads
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.req_type == REQ_SEARCH) begin
            key_q   <= in_data_i.data_value;
            lo_q    <= '0;
            hi_q    <= hi_init;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (lo_q > hi_q) begin
            res_found_q <= 1'b0;
            res_idx_q   <= '0;
            state_q     <= S_DONE;
          end else begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          m1_q    <= m1_c;
          m2_q    <= m2_c;
          state_q <= S_CMP1;
        end
        S_CMP1: begin
          eq1_q   <= cmp_eq;
          lt1_q   <= cmp_lt;
          state_q <= S_CMP2;
        end
        S_CMP2: begin
          state_q <= S_MUL;
          if (eq1_q) begin
            res_found_q <= 1'b1;
            res_idx_q   <= m1_ext[ENTRY_W-1:0];
            state_q     <= S_DONE;
          end else if (cmp_eq) begin
            res_found_q <= 1'b1;
            res_idx_q   <= m2_ext[ENTRY_W-1:0];
            state_q     <= S_DONE;
          end else if (lt1_q) begin
            hi_q <= m1_q - CW'(1);
          end else if (cmp_gt) begin
            lo_q <= m2_q + CW'(1);
          end else begin
            lo_q <= m1_q + CW'(1);
            hi_q <= m2_q - CW'(1);
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_data_q.found       <= res_found_q;
            out_data_q.found_index <= res_idx_q;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/stts_lookup_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sorted-table ternary search unit: watches both beat
// channels and the APB port, predicts each search result. Uses stts_pkg.
module stts_lookup_checker #(
  parameter int DEPTH = stts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  stts_pkg::in_beat_t            in_data_i,
  // Result channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  stts_pkg::out_beat_t           out_data_i,
  // APB port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stts_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  // Status to the testbench top
  output int                            pending_o,
  output int                            fail_count_o
);

  import stts_pkg::*;

  logic signed [DATA_W-1:0] table_copy [DEPTH];
  logic [LEN_W-1:0]         active_len = '0;
  out_beat_t                lookup_q [$];
  int                       fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  // Ternary search over the entries in use; m1 is probed before m2
  function automatic out_beat_t ternary_lookup(logic signed [DATA_W-1:0] key);
    longint    used, lo, hi, third, m1, m2;
    out_beat_t res;
    res  = '0;
    used = (active_len > DEPTH) ? DEPTH : active_len;
    lo   = 0;
    hi   = used - 1;
    while (lo <= hi) begin
      third = (hi - lo) / 3;
      m1    = lo + third;
      m2    = hi - third;
      if (table_copy[m1] == key) begin
        res.found       = 1'b1;
        res.found_index = m1[ENTRY_W-1:0];
        return res;
      end
      if (table_copy[m2] == key) begin
        res.found       = 1'b1;
        res.found_index = m2[ENTRY_W-1:0];
        return res;
      end
      if (key < table_copy[m1]) begin
        hi = m1 - 1;
      end else if (key > table_copy[m2]) begin
        lo = m2 + 1;
      end else begin
        lo = m1 + 1;
        hi = m2 - 1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      active_len = '0;
      lookup_q.delete();
      pending_o <= 0;
    end else begin
      // Track register writes, check read-back of the length register
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[PADDR_W-1:2] == REG_TABLE_LENGTH && paddr[1:0] == 2'b00)
            active_len = pwdata[LEN_W-1:0];
        end else if (paddr[PADDR_W-1:2] == REG_TABLE_LENGTH && paddr[1:0] == 2'b00) begin
          if (prdata !== 32'(active_len))
            report_mismatch($sformatf("table_length read %h, want %h",
                                      prdata, 32'(active_len)));
        end
      end

      // Apply loads, queue a prediction for every search
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == REQ_LOAD) begin
          if (int'(in_data_i.entry_index) < DEPTH)
            table_copy[in_data_i.entry_index] = in_data_i.data_value;
        end else begin
          lookup_q.push_back(ternary_lookup(in_data_i.data_value));
        end
      end

      // Compare each result beat with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat found=%b index=%0d",
                                    out_data_i.found, out_data_i.found_index));
        end else begin
          want = lookup_q.pop_front();
          if (out_data_i.found !== want.found)
            report_mismatch($sformatf("found %b, want %b",
                                      out_data_i.found, want.found));
          if (out_data_i.found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, want %0d",
                                      out_data_i.found_index, want.found_index));
        end
      end

      pending_o <= lookup_q.size();
    end
  end

endmodule

// ===== tb/sorted_table_ternary_search_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for sorted_table_ternary_search_unit: clock, reset, APB and
// beat stimulus, verdict. Uses stts_pkg and stts_lookup_checker.
module sorted_table_ternary_search_unit_tb;
  import stts_pkg::*;

  localparam int RANDOM_BEATS   = 650;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_LOAD    = 8;
  localparam int SETTLE_END     = 150;
  localparam int SMALL_MAX      = 40;
  localparam int PREFIX_LEN     = 64;

  // Unmapped register index, used to check that stray writes are dropped
  localparam logic [PADDR_W-3:0] REG_UNMAPPED = 1'b1;

  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_beat_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_beat_t          out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  int gap_pct     = 0;
  int stall_pct   = 0;
  int idle_cycles = 0;
  int beats_sent  = 0;
  int pending;
  int fail_count;

  // Stimulus-side copy of the table, used only to pick search keys
  logic signed [DATA_W-1:0] shadow_tbl [TABLE_DEPTH_DEF];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_table_ternary_search_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  stts_lookup_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: end the run after too many cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog expired, %0d results outstanding", $time, pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic reg_access(logic wr, logic [PADDR_W-3:0] index, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drive one request beat and hold it until accepted
  task automatic send_beat(logic kind, logic [ENTRY_W-1:0] idx,
                           logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_i.req_type    <= kind;
    in_data_i.entry_index <= idx;
    in_data_i.data_value  <= val;
    if (kind == REQ_LOAD) shadow_tbl[idx] = val;
    beats_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every search has answered, then settle
  task automatic wait_quiet(int settle);
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Load entries [first, first+count) with ascending values in [floor_v, ceil_v]
  task automatic load_ascending(int first, int count, longint floor_v, longint ceil_v);
    longint v, span;
    int     r;
    span = (ceil_v - floor_v) / (count + 1);
    if (span < 1) span = 1;
    v = ($urandom_range(0, 3) == 0) ? floor_v
                                    : floor_v + $urandom_range(0, int'(span));
    for (int i = 0; i < count; i++) begin
      send_beat(REQ_LOAD, ENTRY_W'(first + i), v[DATA_W-1:0]);
      r = $urandom_range(0, 7);
      if (r == 0)      v = v;                                   // duplicate key
      else if (r < 3)  v = v + $urandom_range(1, 3);
      else             v = v + $urandom_range(1, int'(span));
      if (v > ceil_v) v = ceil_v;
    end
  endtask

  // Mostly keys present in the used entries, some neighbors, noise and extremes
  function automatic logic signed [DATA_W-1:0] pick_key(int used);
    int                       r;
    logic signed [DATA_W-1:0] k;
    r = $urandom_range(0, 99);
    if (used == 0 || (r >= 75 && r < 90)) begin
      k = $urandom();
    end else if (r < 60) begin
      k = shadow_tbl[$urandom_range(0, used - 1)];
    end else if (r < 75) begin
      k = shadow_tbl[$urandom_range(0, used - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    end else begin
      case ($urandom_range(0, 3))
        0:       k = KEY_MIN;
        1:       k = KEY_MAX;
        2:       k = '0;
        default: k = -1;
      endcase
    end
    return k;
  endfunction

  initial begin
    int len, used, n_search, r, phase, start_beats;
    logic [31:0] len_word;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: any search misses
    reg_access(1'b1, REG_TABLE_LENGTH, 32'd0);
    reg_access(1'b0, REG_TABLE_LENGTH, 32'd0);
    send_beat(REQ_SEARCH, '1, 32'sd0);
    send_beat(REQ_SEARCH, '0, KEY_MIN);

    // Small table with extremes and duplicates, plus the top entry
    send_beat(REQ_LOAD, 10'd0, KEY_MIN);
    send_beat(REQ_LOAD, 10'd1, -32'sd5);
    send_beat(REQ_LOAD, 10'd2, -32'sd5);
    send_beat(REQ_LOAD, 10'd3, 32'sd0);
    send_beat(REQ_LOAD, 10'd4, 32'sd7);
    send_beat(REQ_LOAD, 10'd5, 32'sd7);
    send_beat(REQ_LOAD, 10'd6, 32'sd100);
    send_beat(REQ_LOAD, 10'd7, KEY_MAX);
    send_beat(REQ_LOAD, '1, 32'sh5A5A_A5A5);
    wait_quiet(SETTLE_LOAD);
    reg_access(1'b1, REG_TABLE_LENGTH, 32'd8);
    reg_access(1'b0, REG_TABLE_LENGTH, 32'd0);
    send_beat(REQ_SEARCH, '1, KEY_MIN);
    send_beat(REQ_SEARCH, '0, KEY_MAX);
    send_beat(REQ_SEARCH, 10'h155, -32'sd5);
    send_beat(REQ_SEARCH, 10'h2AA, 32'sd7);
    send_beat(REQ_SEARCH, '0, 32'sd0);
    send_beat(REQ_SEARCH, '0, 32'sd100);
    send_beat(REQ_SEARCH, '0, 32'sd1);
    send_beat(REQ_SEARCH, '0, KEY_MIN + 1);

    // Single entry, then a stray write that must leave the length alone
    wait_quiet(SETTLE_LOAD);
    reg_access(1'b1, REG_TABLE_LENGTH, 32'd1);
    reg_access(1'b1, REG_UNMAPPED, 32'd8);
    reg_access(1'b0, REG_TABLE_LENGTH, 32'd0);
    send_beat(REQ_SEARCH, '0, KEY_MIN);
    send_beat(REQ_SEARCH, '0, 32'sd7);

    // Break the ordering and search the misplaced key
    wait_quiet(SETTLE_LOAD);
    reg_access(1'b1, REG_TABLE_LENGTH, 32'd8);
    send_beat(REQ_LOAD, 10'd3, -32'sd1000);
    send_beat(REQ_SEARCH, '0, -32'sd1000);
    send_beat(REQ_SEARCH, '0, 32'sd7);
    wait_quiet(SETTLE_LOAD);

    // Fill the whole table with ascending non-negative keys
    load_ascending(0, TABLE_DEPTH_DEF, 0, KEY_MAX);
    wait_quiet(SETTLE_LOAD);

    // Random phases; prefix below PREFIX_LEN holds negative keys, rest stays sorted
    phase       = 0;
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 83; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase

      r = $urandom_range(0, 99);
      if (r < 5)       len = 0;
      else if (r < 70) len = $urandom_range(1, SMALL_MAX);
      else if (r < 85) len = $urandom_range(PREFIX_LEN + 1, TABLE_DEPTH_DEF - 1);
      else if (r < 92) len = TABLE_DEPTH_DEF;
      else             len = $urandom_range(TABLE_DEPTH_DEF + 1, 2047);
      used = (len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : len;

      // Upper register bits carry junk now and then
      len_word = 32'(len);
      if ($urandom_range(0, 3) == 0) len_word = len_word | ($urandom() & 32'hFFFF_F800);
      reg_access(1'b1, REG_TABLE_LENGTH, len_word);
      reg_access(1'b0, REG_TABLE_LENGTH, 32'd0);

      if (used > 0 && used <= SMALL_MAX)
        load_ascending(0, used, KEY_MIN, -1);
      else if (used > SMALL_MAX)
        load_ascending(0, PREFIX_LEN, KEY_MIN, -1);

      // Searches, with an occasional stray load into the prefix
      n_search = $urandom_range(10, 30);
      for (int i = 0; i < n_search; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(REQ_LOAD, ENTRY_W'($urandom_range(0, PREFIX_LEN - 1)), $urandom());
        else
          send_beat(REQ_SEARCH, ENTRY_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)),
                    pick_key(used));
      end
      wait_quiet(SETTLE_LOAD);
      phase++;
    end

    wait_quiet(SETTLE_END);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
